// ===== sv/scfh_pkg.sv =====
// Shared types, constants and helper functions for the serial command frame handler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package scfh_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES    = 14;
    localparam int IDX_W          = $clog2(FRAME_BYTES);
    localparam int CMD_FIFO_DEPTH = 2;

    // Framing and answer constants.
    localparam logic [7:0] SYNC_FIRST     = 8'h55;
    localparam logic [7:0] SYNC_SECOND    = 8'hAA;
    localparam logic [7:0] LEN_CODE       = 8'h0A;
    localparam logic [7:0] ANSWER_CODE    = 8'h90;
    localparam logic [7:0] BROADCAST_ADDR = 8'h00;

    // Function codes.
    localparam logic [7:0] FUNC_MOVE       = 8'h01;
    localparam logic [7:0] FUNC_LAST_BASIC = 8'h04;
    localparam logic [7:0] FUNC_SPEED      = 8'h04;
    localparam logic [7:0] FUNC_STOP       = 8'h53;

    // Byte positions inside request and answer frames.
    localparam int POS_SYNC_FIRST  = 0;
    localparam int POS_SYNC_SECOND = 1;
    localparam int POS_LEN         = 2;
    localparam int POS_FUNC        = 3;
    localparam int POS_V1_LO       = 4;
    localparam int POS_V1_HI       = 5;
    localparam int POS_V2_LO       = 6;
    localparam int POS_V2_HI       = 7;
    localparam int POS_MASK        = 8;
    localparam int POS_ADDR        = 10;
    localparam int POS_SUM_FIRST   = 2;
    localparam int POS_SUM_LAST    = 12;
    localparam int POS_ANS_CODE    = 3;
    localparam int POS_ANS_FUNC    = 4;
    localparam int POS_CHECK       = FRAME_BYTES - 1;

    // Receive phase of the frame parser.
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GOT55,
        PH_COLLECT
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SLAVE_ADDRESS,
        REG_AXIS1_LOWER,
        REG_AXIS1_UPPER,
        REG_AXIS2_LOWER,
        REG_AXIS2_UPPER
    } cfg_reg_t;

    // Configuration values as seen by the datapath.
    typedef struct packed {
        logic        [7:0]  slave_address;
        logic        [15:0] axis1_lower;
        logic        [15:0] axis1_upper;
        logic signed [15:0] axis2_lower;
        logic signed [15:0] axis2_upper;
    } cfg_t;

    // Decoded command outcome, carried with every answer byte.
    typedef struct packed {
        logic        [6:0]  command_code;
        logic        [1:0]  move_mask;
        logic        [15:0] axis1_target;
        logic signed [15:0] axis2_target;
        logic        [1:0]  speed_mask;
        logic        [15:0] speed_one;
        logic        [15:0] speed_two;
        logic        [1:0]  stop_mask;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Answer frame byte at a given position.
    function automatic logic [7:0] answer_byte(
        input logic [IDX_W-1:0] pos,
        input logic [6:0]       func,
        input logic [7:0]       slave
    );
        logic [7:0] sum;
        logic [7:0] res;
        sum = LEN_CODE + ANSWER_CODE + {1'b0, func} + slave;
        unique case (pos)
            IDX_W'(POS_SYNC_FIRST):  res = SYNC_FIRST;
            IDX_W'(POS_SYNC_SECOND): res = SYNC_SECOND;
            IDX_W'(POS_LEN):         res = LEN_CODE;
            IDX_W'(POS_ANS_CODE):    res = ANSWER_CODE;
            IDX_W'(POS_ANS_FUNC):    res = {1'b0, func};
            IDX_W'(POS_ADDR):        res = slave;
            IDX_W'(POS_CHECK):       res = sum;
            default:                 res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/scfh_frame_parser.sv =====
// Front end: sync hunt, request collection, frame checks and command decode.
// Depends on scfh_pkg; pushes decoded commands into scfh_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module scfh_frame_parser
    import scfh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire cfg_t         cfg,
    input  wire fifo_status_t fifo_status,
    output logic              push,
    output cmd_t              cmd
);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;

    // Stored request fields.
    logic [7:0]  len_reg;
    logic [7:0]  func_reg;
    logic [15:0] v1_reg;
    logic [15:0] v2_reg;
    logic [1:0]  mask_reg;
    logic [7:0]  addr_reg;

    logic accept;
    logic at_last;
    logic frame_ok;

    assign accept  = in_valid && in_ready;
    assign at_last = (idx_reg == IDX_W'(POS_CHECK));

    // Frame checks on the final byte.
    always_comb
    begin
        frame_ok = (sum_reg == rx_byte)
                && (len_reg == LEN_CODE)
                && ((addr_reg == cfg.slave_address) || (addr_reg == BROADCAST_ADDR))
                && ((func_reg <= FUNC_LAST_BASIC) || (func_reg == FUNC_STOP));
    end

    // Next-state logic of the receive phase.
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (accept && (rx_byte == SYNC_FIRST))
                begin
                    phase_next = PH_GOT55;
                end
            end
            PH_GOT55:
            begin
                if (accept)
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_COLLECT;
                        idx_next   = IDX_W'(POS_LEN);
                        sum_next   = 8'h00;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_COLLECT:
            begin
                if (accept)
                begin
                    if ((idx_reg >= IDX_W'(POS_SUM_FIRST)) && (idx_reg <= IDX_W'(POS_SUM_LAST)))
                    begin
                        sum_next = sum_reg + rx_byte;
                    end
                    if (at_last)
                    begin
                        phase_next = PH_HUNT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                idx_next   = '0;
            end
        endcase
    end

    // Outputs of the receive phase: hold off the final byte while the queue is full.
    always_comb
    begin
        in_ready = 1'b1;
        push     = 1'b0;
        unique case (phase_reg)
            PH_HUNT, PH_GOT55:
            begin
                in_ready = 1'b1;
            end
            PH_COLLECT:
            begin
                in_ready = !(at_last && fifo_status.full);
                push     = in_valid && in_ready && at_last && frame_ok;
            end
            default:
            begin
                in_ready = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    // Request field capture; each field has its own byte position.
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_COLLECT))
        begin
            if (idx_reg == IDX_W'(POS_LEN))   len_reg       <= rx_byte;
            if (idx_reg == IDX_W'(POS_FUNC))  func_reg      <= rx_byte;
            if (idx_reg == IDX_W'(POS_V1_LO)) v1_reg[7:0]   <= rx_byte;
            if (idx_reg == IDX_W'(POS_V1_HI)) v1_reg[15:8]  <= rx_byte;
            if (idx_reg == IDX_W'(POS_V2_LO)) v2_reg[7:0]   <= rx_byte;
            if (idx_reg == IDX_W'(POS_V2_HI)) v2_reg[15:8]  <= rx_byte;
            if (idx_reg == IDX_W'(POS_MASK))  mask_reg      <= rx_byte[1:0];
            if (idx_reg == IDX_W'(POS_ADDR))  addr_reg      <= rx_byte;
        end
    end

    // Command decode with limit clamping of move targets, lower limit first, upper limit last.
    always_comb
    begin
        logic        [15:0] t1;
        logic signed [15:0] t2;
        t1  = v1_reg;
        t2  = $signed(v2_reg);
        cmd = '0;
        if (t1 < cfg.axis1_lower)
        begin
            t1 = cfg.axis1_lower;
        end
        if (t1 > cfg.axis1_upper)
        begin
            t1 = cfg.axis1_upper;
        end
        if (t2 < cfg.axis2_lower)
        begin
            t2 = cfg.axis2_lower;
        end
        if (t2 > cfg.axis2_upper)
        begin
            t2 = cfg.axis2_upper;
        end
        cmd.command_code = func_reg[6:0];
        if (func_reg == FUNC_MOVE)
        begin
            cmd.move_mask    = mask_reg;
            cmd.axis1_target = mask_reg[0] ? t1 : 16'h0000;
            cmd.axis2_target = mask_reg[1] ? t2 : 16'sh0000;
        end
        else if (func_reg == FUNC_SPEED)
        begin
            cmd.speed_mask = mask_reg;
            cmd.speed_one  = mask_reg[0] ? v1_reg : 16'h0000;
            cmd.speed_two  = mask_reg[1] ? v2_reg : 16'h0000;
        end
        else if (func_reg == FUNC_STOP)
        begin
            cmd.stop_mask = mask_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/scfh_cmd_fifo.sv =====
// Short command queue between the frame parser and the answer generator.
// Depends on scfh_pkg for the command record and status types.
`timescale 1ns / 1ps
`default_nettype none

module scfh_cmd_fifo
    import scfh_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire cmd_t   push_cmd,
    input  wire logic   pop,
    output cmd_t        head,
    output fifo_status_t status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries[rd_ptr_reg];

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/scfh_answer_gen.sv =====
// Back end: plays out the fourteen answer bytes of the command at the queue head.
// Depends on scfh_pkg; reads from scfh_cmd_fifo and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module scfh_answer_gen
    import scfh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cmd_t         head,
    input  wire fifo_status_t fifo_status,
    output logic              pop,
    input  wire logic [7:0]   slave_address,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        tx_byte,
    output logic              last_byte,
    output cmd_t              cmd_out
);

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    cmd_t             cmd_reg;
    logic             load;
    logic             at_last;

    // The output slot takes a new byte when empty or when its transfer completes, if the queue is not empty.
    assign load    = (!valid_reg || out_ready) && !fifo_status.empty;
    assign at_last = (pos_reg == IDX_W'(POS_CHECK));
    assign pop     = load && at_last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = at_last ? '0 : pos_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= answer_byte(pos_reg, head.command_code, slave_address);
            last_reg <= at_last;
            cmd_reg  <= head;
        end
    end

    assign out_valid = valid_reg;
    assign tx_byte   = byte_reg;
    assign last_byte = last_reg;
    assign cmd_out   = cmd_reg;

endmodule

`default_nettype wire

// ===== sv/serial_command_frame_handler_core.sv =====
// Serial command frame handler, top level.
// Takes one received byte per cycle; the final request byte waits only while two answers are queued.
// The first answer byte is registered after the command has been written into the queue,
// then the fourteen answer bytes, counted by pos_reg, leave one per cycle while out_ready is high.
// Reset clears the parser, queue and output stage and loads the register reset values.
// Depends on scfh_pkg, scfh_frame_parser, scfh_cmd_fifo and scfh_answer_gen.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_frame_handler_core
    import scfh_pkg::*;
#(
    parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic [7:0]        tx_byte,
    output logic              last_byte,
    output logic [6:0]        command_code,
    output logic [1:0]        move_mask,
    output logic [15:0]       axis1_target,
    output logic signed [15:0] axis2_target,
    output logic [1:0]        speed_mask,
    output logic [15:0]       speed_one,
    output logic [15:0]       speed_two,
    output logic [1:0]        stop_mask,
    output logic              out_valid,
    input  wire logic         out_ready
);

    cfg_t         cfg_reg;
    fifo_status_t fifo_status;
    cmd_t         parsed_cmd;
    cmd_t         head_cmd;
    cmd_t         cmd_out;
    logic         push;
    logic         pop;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= 8'h01;
            cfg_reg.axis1_lower   <= 16'h0000;
            cfg_reg.axis1_upper   <= 16'hFFFF;
            cfg_reg.axis2_lower   <= 16'sh8000;
            cfg_reg.axis2_upper   <= 16'sh7FFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_data[7:0];
                REG_AXIS1_LOWER:   cfg_reg.axis1_lower   <= cfg_data;
                REG_AXIS1_UPPER:   cfg_reg.axis1_upper   <= cfg_data;
                REG_AXIS2_LOWER:   cfg_reg.axis2_lower   <= $signed(cfg_data);
                REG_AXIS2_UPPER:   cfg_reg.axis2_upper   <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    scfh_frame_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .push        (push),
        .cmd         (parsed_cmd)
    );

    scfh_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (parsed_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .status   (fifo_status)
    );

    scfh_answer_gen u_answer (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_cmd),
        .fifo_status   (fifo_status),
        .pop           (pop),
        .slave_address (cfg_reg.slave_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_byte       (tx_byte),
        .last_byte     (last_byte),
        .cmd_out       (cmd_out)
    );

    // Command outcome fields on their own ports.
    assign command_code = cmd_out.command_code;
    assign move_mask    = cmd_out.move_mask;
    assign axis1_target = cmd_out.axis1_target;
    assign axis2_target = cmd_out.axis2_target;
    assign speed_mask   = cmd_out.speed_mask;
    assign speed_one    = cmd_out.speed_one;
    assign speed_two    = cmd_out.speed_two;
    assign stop_mask    = cmd_out.stop_mask;

endmodule

`default_nettype wire

// ===== tb/sv/scfh_answer_checker.sv =====
// Answer checker for the serial command frame handler core.
// Tracks the receive parser and register state on its own, predicts every answer byte and
// compares the answer channel against it. Depends on scfh_pkg.
`timescale 1ns / 1ps

module scfh_answer_checker
    import scfh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        last_byte,
    input  wire logic [6:0]  command_code,
    input  wire logic [1:0]  move_mask,
    input  wire logic [15:0] axis1_target,
    input  wire logic [15:0] axis2_target,
    input  wire logic [1:0]  speed_mask,
    input  wire logic [15:0] speed_one,
    input  wire logic [15:0] speed_two,
    input  wire logic [1:0]  stop_mask,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    output int               error_count,
    output int               pending_count
);

    localparam int REPORT_LIMIT = 10;

    // One answer byte together with the command outcome it carries.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        cmd_t       cmd;
    } answer_beat_t;

    answer_beat_t answer_beats [$];
    cfg_t         regs;
    phase_t       rx_phase;
    int           rx_index;
    logic [7:0]   rx_frame [FRAME_BYTES];
    logic [7:0]   rx_sum;

    function automatic string beat_text(input answer_beat_t x);
        return $sformatf("tx=%h last=%b cmd=%h move=%b a1=%h a2=%h spd=%b s1=%h s2=%h stop=%b",
                         x.tx_byte, x.last_byte, x.cmd.command_code, x.cmd.move_mask,
                         x.cmd.axis1_target, x.cmd.axis2_target, x.cmd.speed_mask,
                         x.cmd.speed_one, x.cmd.speed_two, x.cmd.stop_mask);
    endfunction

    function automatic void note_failure(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] answer check: %s", $realtime, what);
    endfunction

    // Validate a completed request and queue the fourteen answer bytes it produces.
    function automatic void queue_answer();
        logic        [7:0]  func;
        logic        [7:0]  mask;
        logic        [7:0]  sum;
        logic        [15:0] v1;
        logic        [15:0] v2;
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] lo2;
        logic signed [15:0] hi2;
        logic        [7:0]  ans [FRAME_BYTES];
        cmd_t               cmd;
        answer_beat_t       beat;

        func = rx_frame[POS_FUNC];
        mask = rx_frame[POS_MASK];
        v1   = {rx_frame[POS_V1_HI], rx_frame[POS_V1_LO]};
        v2   = {rx_frame[POS_V2_HI], rx_frame[POS_V2_LO]};

        // Any failed check drops the frame silently.
        if (rx_sum != rx_frame[POS_CHECK])
            return;
        if (rx_frame[POS_LEN] != LEN_CODE)
            return;
        if (rx_frame[POS_ADDR] != regs.slave_address && rx_frame[POS_ADDR] != BROADCAST_ADDR)
            return;
        if (func > FUNC_LAST_BASIC && func != FUNC_STOP)
            return;

        cmd = '0;
        cmd.command_code = func[6:0];
        if (func == FUNC_MOVE)
        begin
            // Lower limit first, then upper, so the upper limit wins when they cross.
            cmd.move_mask = mask[1:0];
            if (mask[0])
            begin
                t1 = v1;
                if (t1 < regs.axis1_lower)
                    t1 = regs.axis1_lower;
                if (t1 > regs.axis1_upper)
                    t1 = regs.axis1_upper;
                cmd.axis1_target = t1;
            end
            if (mask[1])
            begin
                t2  = v2;
                lo2 = regs.axis2_lower;
                hi2 = regs.axis2_upper;
                if (t2 < lo2)
                    t2 = lo2;
                if (t2 > hi2)
                    t2 = hi2;
                cmd.axis2_target = t2;
            end
        end
        else if (func == FUNC_SPEED)
        begin
            cmd.speed_mask = mask[1:0];
            if (mask[0])
                cmd.speed_one = v1;
            if (mask[1])
                cmd.speed_two = v2;
        end
        else if (func == FUNC_STOP)
        begin
            cmd.stop_mask = mask[1:0];
        end

        // Fixed answer layout with the station address and a trailing checksum.
        foreach (ans[k])
            ans[k] = 8'h00;
        ans[POS_SYNC_FIRST]  = SYNC_FIRST;
        ans[POS_SYNC_SECOND] = SYNC_SECOND;
        ans[POS_LEN]         = LEN_CODE;
        ans[POS_ANS_CODE]    = ANSWER_CODE;
        ans[POS_ANS_FUNC]    = func;
        ans[POS_ADDR]        = regs.slave_address;
        sum = 8'h00;
        for (int k = POS_SUM_FIRST; k <= POS_SUM_LAST; k++)
            sum += ans[k];
        ans[POS_CHECK] = sum;

        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            beat.tx_byte   = ans[k];
            beat.last_byte = (k == POS_CHECK);
            beat.cmd       = cmd;
            answer_beats.push_back(beat);
        end
    endfunction

    // Sync hunting and frame collection, one received byte at a time.
    function automatic void take_rx_byte(input logic [7:0] b);
        case (rx_phase)
            PH_GOT55:
            begin
                if (b == SYNC_SECOND)
                begin
                    rx_frame[POS_SYNC_SECOND] = b;
                    rx_index = POS_LEN;
                    rx_sum   = 8'h00;
                    rx_phase = PH_COLLECT;
                end
                else
                begin
                    // A broken sync pair drops both bytes.
                    rx_phase = PH_HUNT;
                end
            end
            PH_COLLECT:
            begin
                rx_frame[rx_index] = b;
                if (rx_index >= POS_SUM_FIRST && rx_index <= POS_SUM_LAST)
                    rx_sum += b;
                rx_index++;
                if (rx_index == FRAME_BYTES)
                begin
                    rx_phase = PH_HUNT;
                    rx_index = 0;
                    queue_answer();
                end
            end
            default:
            begin
                if (b == SYNC_FIRST)
                begin
                    rx_frame[POS_SYNC_FIRST] = b;
                    rx_phase = PH_GOT55;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    // Watch all three channels on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        answer_beat_t got;
        answer_beat_t want;
        if (!rst_n)
        begin
            answer_beats.delete();
            regs.slave_address = 8'd1;
            regs.axis1_lower   = 16'h0000;
            regs.axis1_upper   = 16'hFFFF;
            regs.axis2_lower   = 16'h8000;
            regs.axis2_upper   = 16'h7FFF;
            rx_phase           = PH_HUNT;
            rx_index           = 0;
            rx_sum             = 8'h00;
            error_count        = 0;
            pending_count      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.tx_byte          = tx_byte;
                got.last_byte        = last_byte;
                got.cmd.command_code = command_code;
                got.cmd.move_mask    = move_mask;
                got.cmd.axis1_target = axis1_target;
                got.cmd.axis2_target = axis2_target;
                got.cmd.speed_mask   = speed_mask;
                got.cmd.speed_one    = speed_one;
                got.cmd.speed_two    = speed_two;
                got.cmd.stop_mask    = stop_mask;
                if (answer_beats.size() == 0)
                begin
                    note_failure({"transfer with nothing expected: ", beat_text(got)});
                end
                else
                begin
                    want = answer_beats.pop_front();
                    if (got !== want)
                        note_failure({"mismatch\n  expected ", beat_text(want),
                                      "\n  actual   ", beat_text(got)});
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SLAVE_ADDRESS: regs.slave_address = cfg_data[7:0];
                    REG_AXIS1_LOWER:   regs.axis1_lower   = cfg_data;
                    REG_AXIS1_UPPER:   regs.axis1_upper   = cfg_data;
                    REG_AXIS2_LOWER:   regs.axis2_lower   = cfg_data;
                    REG_AXIS2_UPPER:   regs.axis2_upper   = cfg_data;
                    default:           ;
                endcase
            end

            if (in_valid && in_ready)
                take_rx_byte(rx_byte);

            pending_count = answer_beats.size();
        end
    end

endmodule

// ===== tb/sv/tb_serial_command_frame_handler_core.sv =====
// Testbench top for serial_command_frame_handler_core: clock, reset, request bytes,
// register writes and answer back-pressure; the verdict comes from scfh_answer_checker.
// Depends on scfh_pkg, serial_command_frame_handler_core and scfh_answer_checker.
`timescale 1ns / 1ps

module tb_serial_command_frame_handler_core;
    import scfh_pkg::*;

    localparam int         SETTLE_CYCLES    = 8;
    localparam int         LONG_HOLD_CYCLES = 200;
    localparam longint     TIMEOUT_NS       = 1_200_000;
    localparam logic [2:0] REG_UNUSED       = 3'd7;

    // Accepted functions that only produce the plain answer.
    localparam logic [7:0] FUNC_PLAIN_ZERO  = 8'h00;
    localparam logic [7:0] FUNC_PLAIN_TWO   = 8'h02;
    localparam logic [7:0] FUNC_PLAIN_THREE = 8'h03;

    typedef enum int {
        DEFECT_NONE,
        DEFECT_SUM,
        DEFECT_LENGTH,
        DEFECT_ADDRESS,
        DEFECT_FUNCTION,
        DEFECT_SYNC
    } defect_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         rx_byte;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         tx_byte;
    logic               last_byte;
    logic [6:0]         command_code;
    logic [1:0]         move_mask;
    logic [15:0]        axis1_target;
    logic signed [15:0] axis2_target;
    logic [1:0]         speed_mask;
    logic [15:0]        speed_one;
    logic [15:0]        speed_two;
    logic [1:0]         stop_mask;
    logic               out_valid;
    logic               out_ready;

    int                 error_count;
    int                 pending;
    logic               hold_request;
    logic               quiet_tail;
    bit                 sender_gaps;
    int                 func_turn;
    logic [7:0]         cur_slave;
    logic [15:0]        lim_a1_lo;
    logic [15:0]        lim_a1_hi;
    logic [15:0]        lim_a2_lo;
    logic [15:0]        lim_a2_hi;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    serial_command_frame_handler_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .rx_byte      (rx_byte),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tx_byte      (tx_byte),
        .last_byte    (last_byte),
        .command_code (command_code),
        .move_mask    (move_mask),
        .axis1_target (axis1_target),
        .axis2_target (axis2_target),
        .speed_mask   (speed_mask),
        .speed_one    (speed_one),
        .speed_two    (speed_two),
        .stop_mask    (stop_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    scfh_answer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .rx_byte       (rx_byte),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .tx_byte       (tx_byte),
        .last_byte     (last_byte),
        .command_code  (command_code),
        .move_mask     (move_mask),
        .axis1_target  (axis1_target),
        .axis2_target  (axis2_target),
        .speed_mask    (speed_mask),
        .speed_one     (speed_one),
        .speed_two     (speed_two),
        .stop_mask     (stop_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .error_count   (error_count),
        .pending_count (pending)
    );

    function automatic logic [7:0] accepted_func(input int n);
        case (n % 6)
            0:       return FUNC_PLAIN_ZERO;
            1:       return FUNC_MOVE;
            2:       return FUNC_PLAIN_TWO;
            3:       return FUNC_PLAIN_THREE;
            4:       return FUNC_SPEED;
            default: return FUNC_STOP;
        endcase
    endfunction

    // Values cluster around the current limits and the 16-bit extremes.
    function automatic logic [15:0] pick_word(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return lo - 16'd1;
            2:       return hi;
            3:       return hi + 16'd1;
            4:       return 16'h0000;
            5:       return 16'hFFFF;
            6:       return 16'h7FFF;
            7:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One request byte transfer, with an occasional gap afterwards.
    task automatic send_rx(input logic [7:0] value);
        rx_byte  <= value;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Build a request frame, apply the framing defect if any, and send it.
    task automatic send_frame(input logic [7:0] func, input logic [15:0] v1,
                              input logic [15:0] v2, input logic [7:0] mask,
                              input logic [7:0] addr, input defect_t defect);
        logic [7:0] req [FRAME_BYTES];
        logic [7:0] sum;
        logic [7:0] junk;
        foreach (req[k])
            req[k] = 8'($urandom);
        req[POS_SYNC_FIRST]  = SYNC_FIRST;
        req[POS_SYNC_SECOND] = SYNC_SECOND;
        req[POS_LEN]         = LEN_CODE;
        req[POS_FUNC]        = func;
        req[POS_V1_LO]       = v1[7:0];
        req[POS_V1_HI]       = v1[15:8];
        req[POS_V2_LO]       = v2[7:0];
        req[POS_V2_HI]       = v2[15:8];
        req[POS_MASK]        = mask;
        req[POS_ADDR]        = addr;
        if (defect == DEFECT_LENGTH)
        begin
            do
                junk = 8'($urandom);
            while (junk == LEN_CODE);
            req[POS_LEN] = junk;
        end
        sum = 8'h00;
        for (int k = POS_SUM_FIRST; k <= POS_SUM_LAST; k++)
            sum += req[k];
        req[POS_CHECK] = sum;
        if (defect == DEFECT_SUM)
            req[POS_CHECK] = sum + 8'($urandom_range(1, 255));
        // A broken sync pair ahead of an otherwise good frame.
        if (defect == DEFECT_SYNC)
        begin
            send_rx(SYNC_FIRST);
            do
                junk = 8'($urandom);
            while (junk == SYNC_SECOND);
            send_rx(junk);
        end
        foreach (req[k])
            send_rx(req[k]);
    endtask

    // Random frames with random content; most are well formed.
    task automatic run_phase(input int frames, input bit all_valid);
        logic [7:0] func;
        logic [7:0] addr;
        logic [7:0] junk;
        defect_t    defect;
        for (int f = 0; f < frames; f++)
        begin
            sender_gaps = !quiet_tail && $urandom_range(0, 3) != 0;
            // Line noise between frames never holds a sync byte, so the parser stays in hunt.
            repeat ($urandom_range(0, 2))
            begin
                do
                    junk = 8'($urandom);
                while (junk == SYNC_FIRST);
                send_rx(junk);
            end
            func = accepted_func(func_turn);
            func_turn++;
            addr = $urandom_range(0, 1) ? cur_slave : BROADCAST_ADDR;
            defect = DEFECT_NONE;
            if (!all_valid && $urandom_range(0, 2) == 0)
                defect = defect_t'($urandom_range(DEFECT_SUM, DEFECT_SYNC));
            if (defect == DEFECT_ADDRESS)
            begin
                do
                    addr = 8'($urandom);
                while (addr == cur_slave || addr == BROADCAST_ADDR);
            end
            if (defect == DEFECT_FUNCTION)
            begin
                do
                    func = 8'($urandom);
                while (func <= FUNC_LAST_BASIC || func == FUNC_STOP);
            end
            send_frame(func, pick_word(lim_a1_lo, lim_a1_hi), pick_word(lim_a2_lo, lim_a2_hi),
                       8'($urandom), addr, defect);
        end
    endtask

    // Stop offering bytes and wait until every expected answer byte has come.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers back to back, optionally followed by an unused index.
    task automatic configure(input logic [7:0] slave, input logic [15:0] a1_lo,
                             input logic [15:0] a1_hi, input logic [15:0] a2_lo,
                             input logic [15:0] a2_hi, input bit poke_unused);
        cfg_reg_t    order  [5];
        logic [15:0] values [5];
        order  = '{REG_SLAVE_ADDRESS, REG_AXIS1_LOWER, REG_AXIS1_UPPER,
                   REG_AXIS2_LOWER, REG_AXIS2_UPPER};
        values = '{{8'h00, slave}, a1_lo, a1_hi, a2_lo, a2_hi};
        for (int r = 0; r < 5; r++)
        begin
            cfg_index <= order[r];
            cfg_data  <= values[r];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data  <= 16'hFFFF;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_slave = slave;
        lim_a1_lo = a1_lo;
        lim_a1_hi = a1_hi;
        lim_a2_lo = a2_lo;
        lim_a2_hi = a2_hi;
    endtask

    // Answer side: random stall bursts, calm stretches, and one long hold-off on request.
    initial
    begin : answer_sink
        int idle_left;
        int mode_left;
        bit stalls_on;
        bit hold_taken;
        out_ready  = 1'b0;
        idle_left  = 0;
        mode_left  = 0;
        stalls_on  = 1'b1;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 80);
                stalls_on = $urandom_range(0, 2) != 0;
            end
            mode_left--;
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                idle_left  = LONG_HOLD_CYCLES;
            end
            else if (idle_left == 0 && stalls_on && !quiet_tail && $urandom_range(0, 3) == 0)
            begin
                idle_left = $urandom_range(1, 6);
            end
            if (idle_left > 0)
            begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Request side and verdict.
    initial
    begin : request_source
        rst_n        = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cfg_valid    = 1'b0;
        rx_byte      = '0;
        in_valid     = 1'b0;
        hold_request = 1'b0;
        quiet_tail   = 1'b0;
        sender_gaps  = 1'b1;
        func_turn    = $urandom_range(0, 5);
        cur_slave    = 8'd1;
        lim_a1_lo    = 16'h0000;
        lim_a1_hi    = 16'hFFFF;
        lim_a2_lo    = 16'h8000;
        lim_a2_hi    = 16'h7FFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Noise, a sync byte followed by a second sync byte, a broken pair, then a move
        // frame at the value extremes with every mask bit set, on the reset registers.
        send_rx(8'h13);
        send_rx(SYNC_FIRST);
        send_rx(SYNC_FIRST);
        send_rx(SYNC_SECOND);
        send_rx(SYNC_FIRST);
        send_rx(8'h00);
        send_frame(FUNC_MOVE, 16'hFFFF, 16'h8000, 8'hFF, cur_slave, DEFECT_NONE);
        run_phase(2, 1'b0);
        wait_drained();

        // Narrow window: axis two between -1000 and 1000. The answer side holds off long
        // enough that queued answers back up into the request side.
        configure(8'hFF, 16'h1000, 16'hF000, 16'hFC18, 16'h03E8, 1'b0);
        hold_request <= 1'b1;
        run_phase(4, 1'b1);
        wait_drained();

        // Crossed limits on both axes, broadcast-only address, and a write to an unused index.
        configure(8'h00, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 1'b1);
        run_phase(2, 1'b0);
        wait_drained();

        // Full range written explicitly; no idling on either side from here on.
        quiet_tail <= 1'b1;
        configure(8'h80, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        run_phase(2, 1'b0);
        wait_drained();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
